// ===== hw/rtl/pllc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pllc_pkg
// Shared types and constants of the probe-limited LRU hash cache.
// ----------------------------------------------------------------------------
package pllc_pkg;

	localparam int SLOT_COUNT_DEF  = 256;
	localparam int PROBE_DEPTH_DEF = 8;
	localparam int VALUE_BITS_DEF  = 32;

	localparam int KEY_W   = 64;
	localparam int STAMP_W = 64;
	localparam int PORT_VALUE_W = 32;

	// Request codes.
	localparam logic [1:0] REQ_LOOKUP = 2'd0;
	localparam logic [1:0] REQ_INSERT = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_PROBE
	} state_t;

endpackage

// ===== hw/rtl/pllc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pllc_ram
// Generic single-write, single-read RAM with a registered read.
// ----------------------------------------------------------------------------
module pllc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/probe_limited_lru_hash_cache.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// probe_limited_lru_hash_cache
// Open-addressed key-to-handle cache with a bounded probe window and LRU
// replacement, held in one slot RAM.
// ----------------------------------------------------------------------------
// A request word is taken while the block is idle. Each slot is one RAM entry
// holding valid, tag, stamp and value. The probe window is read one slot per
// cycle through the single read port. When SLOT_COUNT is a power of two the
// base slot is taken from the low key bits; otherwise a second hash step finds
// it, where the key bits are folded through a table of residues of their
// weights. The probe then reads up to PROBE_DEPTH slots and stops early at an
// empty or matching slot. A lookup or insert holds the block until its probe
// ends, and a lookup's result word is set in the holding register as its
// probe ends. A clear, and the pass after reset, write one slot per cycle
// over all SLOT_COUNT slots, during which no request word is taken. One
// finished result waits in a holding register behind the output register, so
// besides the busy states a lookup word is also held off while that holding
// register is still occupied; insert and clear words are not.
// ----------------------------------------------------------------------------
module probe_limited_lru_hash_cache
	import pllc_pkg::*;
#(
	parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
	parameter int PROBE_DEPTH = PROBE_DEPTH_DEF,
	parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              req_type,
	input  logic [KEY_W-1:0]        key_word,
	input  logic [PORT_VALUE_W-1:0] value_in,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    hit,
	output logic [PORT_VALUE_W-1:0] value_out
);

	localparam int  IDX_W = $clog2(SLOT_COUNT);
	localparam int  CNT_W = $clog2(PROBE_DEPTH + 1);
	localparam int  PI_W  = (PROBE_DEPTH > 1) ? $clog2(PROBE_DEPTH) : 1;
	localparam int  ENT_W = 1 + KEY_W + STAMP_W + VALUE_BITS;
	localparam bit  POW2  = (SLOT_COUNT & (SLOT_COUNT - 1)) == 0;
	localparam int  KEY_BYTES = KEY_W / 8;
	// Entry layout: {valid, tag, stamp, value}.
	localparam int  V_LSB = 0;
	localparam int  S_LSB = VALUE_BITS;
	localparam int  T_LSB = VALUE_BITS + STAMP_W;
	localparam int  F_BIT = VALUE_BITS + STAMP_W + KEY_W;

	typedef logic [KEY_W-1:0][IDX_W-1:0]     res_tab_t;
	typedef logic [KEY_BYTES-1:0][IDX_W-1:0] grp_t;

	// Residue of each key bit's weight modulo the slot count.
	function automatic res_tab_t bit_residues();
		res_tab_t t;
		int r;
		r = 1 % SLOT_COUNT;
		for (int k = 0; k < KEY_W; k++) begin
			t[k] = IDX_W'(r);
			r = (2 * r) % SLOT_COUNT;
		end
		return t;
	endfunction

	localparam res_tab_t BIT_RES = bit_residues();

	// Sum of two residues, folded back below the slot count.
	function automatic logic [IDX_W-1:0] mod_add(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
		logic [IDX_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (IDX_W+1)'(SLOT_COUNT)) begin
			s = s - (IDX_W+1)'(SLOT_COUNT);
		end
		return s[IDX_W-1:0];
	endfunction

	// Residue sum of eight terms as a three-level tree.
	function automatic logic [IDX_W-1:0] mod_sum8(grp_t t);
		logic [3:0][IDX_W-1:0] l1;
		logic [1:0][IDX_W-1:0] l2;
		for (int i = 0; i < 4; i++) begin
			l1[i] = mod_add(t[2*i], t[2*i+1]);
		end
		for (int i = 0; i < 2; i++) begin
			l2[i] = mod_add(l1[2*i], l1[2*i+1]);
		end
		return mod_add(l2[0], l2[1]);
	endfunction

	state_t state_q, state_d;

	logic [1:0]            req_q;
	logic [KEY_W-1:0]      key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [IDX_W-1:0]      addr_q, addr_d;
	grp_t                  grp_q, grp_d;
	grp_t                  grp_terms;
	logic                  hstep_q;
	logic [CNT_W-1:0]      iss_q, iss_d;
	logic                  pend_s1, pend_d;
	logic [IDX_W-1:0]      slot_s1;
	logic [PI_W-1:0]       idx_s1;
	logic [STAMP_W-1:0]    min_q, min_d;
	logic [IDX_W-1:0]      victim_q, victim_d;
	logic [STAMP_W-1:0]    cnt_q, cnt_d;
	logic [IDX_W-1:0]      clr_q;
	logic                  res_valid_q, res_set;
	logic                  res_hit_q, res_hit_d;
	logic [PORT_VALUE_W-1:0] res_val_q, res_val_d;
	logic                  out_valid_q, out_load;
	logic                  hit_q;
	logic [PORT_VALUE_W-1:0] vout_q;

	logic                  mem_we;
	logic [IDX_W-1:0]      mem_waddr;
	logic [ENT_W-1:0]      mem_wdata;
	logic [ENT_W-1:0]      mem_rdata;

	logic                  in_acc;
	logic [63:0]           vin64;
	logic [63:0]           vrd64;
	logic                  e_valid;
	logic [KEY_W-1:0]      e_tag;
	logic [STAMP_W-1:0]    e_stamp;
	logic [VALUE_BITS-1:0] e_value;
	logic                  last;
	logic                  newmin;
	logic [IDX_W-1:0]      addr_inc;

	pllc_ram #(
		.WIDTH (ENT_W),
		.DEPTH (SLOT_COUNT)
	) u_slots (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (addr_q),
		.rdata (mem_rdata)
	);

	// Handshake and field decode.
	assign in_stall  = (state_q != ST_IDLE) || (res_valid_q && (req_type == REQ_LOOKUP));
	assign in_acc    = in_valid && !in_stall;
	assign out_load  = res_valid_q && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign value_out = vout_q;

	assign vin64   = {32'b0, value_in};
	assign e_valid = mem_rdata[F_BIT];
	assign e_tag   = mem_rdata[T_LSB +: KEY_W];
	assign e_stamp = mem_rdata[S_LSB +: STAMP_W];
	assign e_value = mem_rdata[V_LSB +: VALUE_BITS];
	assign vrd64   = 64'(e_value);
	assign last    = idx_s1 == PI_W'(PROBE_DEPTH - 1);
	assign newmin  = (idx_s1 == '0) || (e_stamp < min_q);
	assign addr_inc = (addr_q == IDX_W'(SLOT_COUNT - 1)) ? '0 : addr_q + 1'b1;

	// Per-byte residue sums of the key; folded together in the second hash step.
	always_comb begin
		for (int g = 0; g < KEY_BYTES; g++) begin
			for (int b = 0; b < 8; b++) begin
				grp_terms[b] = key_q[8*g + b] ? BIT_RES[8*g + b] : '0;
			end
			grp_d[g] = mod_sum8(grp_terms);
		end
	end

	// Next state, probe evaluation and RAM write.
	always_comb begin
		state_d   = state_q;
		addr_d    = addr_q;
		iss_d     = iss_q;
		pend_d    = 1'b0;
		min_d     = min_q;
		victim_d  = victim_q;
		cnt_d     = cnt_q;
		res_set   = 1'b0;
		res_hit_d = 1'b0;
		res_val_d = '0;
		mem_we    = 1'b0;
		mem_waddr = slot_s1;
		mem_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				if (clr_q == IDX_W'(SLOT_COUNT - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				iss_d = '0;
				if (in_acc) begin
					case (req_type)
						REQ_LOOKUP, REQ_INSERT: state_d = ST_HASH;
						REQ_CLEAR:              state_d = ST_CLEAR;
						default:                state_d = ST_IDLE;
					endcase
				end
			end
			ST_HASH: begin
				if (POW2) begin
					addr_d  = key_q[IDX_W-1:0];
					state_d = ST_PROBE;
				end else if (hstep_q) begin
					addr_d  = mod_sum8(grp_q);
					state_d = ST_PROBE;
				end
			end
			ST_PROBE: begin
				// Issue the next window read while the previous one is judged.
				if (iss_q < CNT_W'(PROBE_DEPTH)) begin
					iss_d  = iss_q + 1'b1;
					addr_d = addr_inc;
					pend_d = 1'b1;
				end
				if (pend_s1) begin
					if (req_q == REQ_LOOKUP) begin
						if (!e_valid) begin
							state_d   = ST_IDLE;
							res_set   = 1'b1;
						end else if (e_tag == key_q) begin
							state_d   = ST_IDLE;
							res_set   = 1'b1;
							res_hit_d = 1'b1;
							res_val_d = vrd64[PORT_VALUE_W-1:0];
							cnt_d     = cnt_q + 1'b1;
							mem_we    = 1'b1;
							mem_wdata = {1'b1, e_tag, cnt_d, e_value};
						end else if (last) begin
							state_d   = ST_IDLE;
							res_set   = 1'b1;
						end
					end else begin
						if (!e_valid || (e_tag == key_q)) begin
							state_d = ST_IDLE;
							cnt_d   = cnt_q + 1'b1;
							mem_we  = 1'b1;
							mem_wdata = {1'b1, key_q, cnt_d, val_q};
						end else begin
							if (newmin) begin
								min_d    = e_stamp;
								victim_d = slot_s1;
							end
							if (last) begin
								state_d   = ST_IDLE;
								cnt_d     = cnt_q + 1'b1;
								mem_we    = 1'b1;
								mem_waddr = victim_d;
								mem_wdata = {1'b1, key_q, cnt_d, val_q};
							end
						end
					end
				end
				if (state_d == ST_IDLE) begin
					pend_d = 1'b0;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			pend_s1     <= 1'b0;
			iss_q       <= '0;
			hstep_q     <= 1'b0;
			res_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			pend_s1 <= pend_d;
			iss_q   <= iss_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end else begin
				clr_q <= '0;
			end
			if (state_q == ST_HASH) begin
				hstep_q <= !hstep_q;
			end else begin
				hstep_q <= 1'b0;
			end
			if (res_set) begin
				res_valid_q <= 1'b1;
			end else if (out_load) begin
				res_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_q <= req_type;
			key_q <= (key_word == '0) ? KEY_W'(1) : key_word;
			val_q <= vin64[VALUE_BITS-1:0];
		end
		if (res_set) begin
			res_hit_q <= res_hit_d;
			res_val_q <= res_val_d;
		end
		if (out_load) begin
			hit_q  <= res_hit_q;
			vout_q <= res_val_q;
		end
		addr_q   <= addr_d;
		grp_q    <= grp_d;
		slot_s1  <= addr_q;
		idx_s1   <= iss_q[PI_W-1:0];
		min_q    <= min_d;
		victim_q <= victim_d;
	end

	// A request word is only taken while idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> (state_q == ST_IDLE))
		else $error("request word taken while busy");

	// A result word appears only after one waited in the holding register.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(res_valid_q))
		else $error("result word without a finished probe");

	// The use counter only ever steps by one.
	assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cnt_q) |-> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("use counter jumped");

	// The slot RAM is written only by a probe or a clearing pass.
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ((state_q == ST_PROBE) || (state_q == ST_CLEAR)))
		else $error("slot write outside probe or clear");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the probe-limited LRU hash cache.
// ----------------------------------------------------------------------------
// Requests go through a model of the slot table with LRU stamps. Each lookup
// queues an expected hit flag and value, and every result word is checked
// against the oldest one. Keys come mostly from a small pool that crowds a
// few probe windows, so updates, evictions and wrap around the table all
// happen. The sender works in bursts, and the receiver stalls on its own
// pattern, including one long hold-off that fills the block.
// ----------------------------------------------------------------------------
module tb
	import pllc_pkg::*;
();

	localparam int NSLOT  = SLOT_COUNT_DEF;
	localparam int NPROBE = PROBE_DEPTH_DEF;
	localparam int NRAND  = 1800;
	localparam int NPOOL  = 24;
	localparam int BASE_PICK [7] = '{0, 3, 4, 252, 253, 254, 255};

	// Model of the slot table; it predicts the result of each lookup.
	class cache_scoreboard;
		logic [KEY_W-1:0]        tag [NSLOT];
		logic [PORT_VALUE_W-1:0] val [NSLOT];
		logic [STAMP_W-1:0]      stamp [NSLOT];
		bit                      used [NSLOT];
		logic [STAMP_W-1:0]      uses;
		bit                      exp_hit [$];
		logic [PORT_VALUE_W-1:0] exp_val [$];
		int                      errors;

		function new();
			uses = '0;
			errors = 0;
			foreach (used[i]) used[i] = 0;
		endfunction

		// Notes an accepted request word and updates the table.
		function void note_request(logic [1:0] req, logic [KEY_W-1:0] key,
				logic [PORT_VALUE_W-1:0] v);
			logic [KEY_W-1:0] h;
			int base;
			int s;
			int victim;
			bit found;
			h = (key == '0) ? 64'd1 : key;
			base = int'(h % NSLOT);
			found = 0;
			victim = base;
			if (req == REQ_LOOKUP) begin
				exp_hit = {exp_hit, 1'b0};
				exp_val = {exp_val, PORT_VALUE_W'(0)};
				for (int i = 0; i < NPROBE; i++) begin
					s = (base + i) % NSLOT;
					if (!used[s]) break;
					if (tag[s] == h) begin
						uses = uses + 1;
						stamp[s] = uses;
						exp_hit[$] = 1;
						exp_val[$] = val[s];
						break;
					end
				end
			end else if (req == REQ_INSERT) begin
				for (int i = 0; i < NPROBE && !found; i++) begin
					s = (base + i) % NSLOT;
					if (!used[s] || tag[s] == h) begin
						victim = s;
						found = 1;
					end
				end
				// No free or matching slot: evict the oldest stamp, earliest wins.
				if (!found) begin
					for (int i = 1; i < NPROBE; i++) begin
						s = (base + i) % NSLOT;
						if (stamp[s] < stamp[victim]) victim = s;
					end
				end
				uses = uses + 1;
				tag[victim] = h;
				val[victim] = v;
				stamp[victim] = uses;
				used[victim] = 1;
			end else if (req == REQ_CLEAR) begin
				foreach (used[i]) used[i] = 0;
			end
		endfunction

		// Checks one accepted result word against the oldest expectation.
		function void check_result(logic h, logic [PORT_VALUE_W-1:0] v);
			if (exp_hit.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result word: hit %0b value %h", h, v);
				return;
			end
			if (h !== exp_hit[0] || v !== exp_val[0]) begin
				errors++;
				if (errors <= 10)
					$display("result word wrong: expected hit %0b value %h, got hit %0b value %h",
						exp_hit[0], exp_val[0], h, v);
			end
			void'(exp_hit.pop_front());
			void'(exp_val.pop_front());
		endfunction

		function int pending();
			return exp_hit.size();
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic [1:0]              req_type;
	logic [KEY_W-1:0]        key_word;
	logic [PORT_VALUE_W-1:0] value_in;
	logic                    out_valid;
	logic                    out_stall;
	logic                    hit;
	logic [PORT_VALUE_W-1:0] value_out;

	cache_scoreboard sb;
	logic [KEY_W-1:0] key_pool [NPOOL];
	int  words_sent;
	bit  hold_wanted;

	probe_limited_lru_hash_cache uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .key_word(key_word), .value_in(value_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.hit(hit), .value_out(value_out)
	);

	// Clock generation.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Run limit.
	initial begin
		#20ms;
		$display("probe_limited_lru_hash_cache: mismatch");
		$finish;
	end

	// Offers one request word and waits for it to be taken.
	task automatic send_word(logic [1:0] req, logic [KEY_W-1:0] key,
			logic [PORT_VALUE_W-1:0] v);
		bit taken;
		in_valid <= 1'b1;
		req_type <= req;
		key_word <= key;
		value_in <= v;
		taken = 0;
		while (!taken) begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end
		sb.note_request(req, key, v);
		words_sent++;
	endtask

	// Drops valid for a random gap now and then; bursts otherwise.
	task automatic maybe_gap();
		int n;
		if ($urandom_range(0, 5) == 0) begin
			n = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic logic [KEY_W-1:0] rand_key();
		return {$urandom(), $urandom()};
	endfunction

	// Result side: random stall pattern out of four modes, with one long hold-off.
	initial begin
		int mode;
		int cyc;
		bit held;
		out_stall = 1'b0;
		mode = 0;
		cyc = 0;
		held = 0;
		forever begin
			@(posedge clk);
			if (hold_wanted && !held) begin
				held = 1;
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
			end
			cyc++;
			if (cyc % 64 == 0) mode = $urandom_range(0, 3);
			case (mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 9) < 3);
				2: out_stall <= cyc[0];
				default: out_stall <= ($urandom_range(0, 9) < 8);
			endcase
		end
	end

	// Result monitor; the word is taken at the next rising edge.
	initial begin
		bit take;
		forever begin
			@(negedge clk);
			take = arst_n && out_valid && !out_stall;
			@(posedge clk);
			if (take) sb.check_result(hit, value_out);
		end
	end

	// Stimulus.
	initial begin
		int k;
		int r;
		sb = new();
		words_sent = 0;
		hold_wanted = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_LOOKUP;
		key_word = '0;
		value_in = '0;
		foreach (key_pool[i])
			key_pool[i] = {$urandom(), 24'($urandom_range(0, 32'hFFFFFF)),
				8'(BASE_PICK[i % 7])};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty table, zero key aliasing one, extremes, ignored code.
		send_word(REQ_LOOKUP, 64'd5, 32'hFFFFFFFF);
		send_word(REQ_INSERT, 64'd0, 32'hFFFFFFFF);
		send_word(REQ_LOOKUP, 64'd1, '0);
		send_word(REQ_LOOKUP, 64'd0, '0);
		send_word(REQ_INSERT, 64'd1, 32'h0);
		send_word(REQ_LOOKUP, 64'd0, '1);
		send_word(REQ_INSERT, '1, 32'hA5A5A5A5);
		send_word(REQ_INSERT, 64'h100, 32'h5A5A5A5A);
		send_word(REQ_LOOKUP, '1, '0);
		send_word(REQ_LOOKUP, 64'h100, '0);
		send_word(2'd3, '1, '1);
		send_word(REQ_LOOKUP, 64'h100, '0);
		// Ten keys on slot 255: the window wraps, then the oldest is evicted.
		for (int i = 0; i < 10; i++)
			send_word(REQ_INSERT, {56'(i + 1), 8'hFF}, 32'(i));
		send_word(REQ_LOOKUP, {56'd1, 8'hFF}, '0);
		send_word(REQ_LOOKUP, {56'd10, 8'hFF}, '0);
		send_word(REQ_CLEAR, '0, '0);
		send_word(REQ_LOOKUP, {56'd10, 8'hFF}, '0);

		// Random part, mostly on the crowded key pool.
		k = 0;
		while (k < NRAND) begin
			logic [KEY_W-1:0] key;
			logic [1:0] req;
			maybe_gap();
			r = $urandom_range(0, 999);
			key = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, NPOOL - 1)]
				: rand_key();
			if (r < 480) req = REQ_LOOKUP;
			else if (r < 970) req = REQ_INSERT;
			else if (r < 985) req = REQ_CLEAR;
			else req = 2'd3;
			if (k == 300) hold_wanted = 1;
			send_word(req, key, $urandom());
			if (req != 2'd3) k++;
		end
		in_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
		if (sb.errors == 0) begin
			$display("probe_limited_lru_hash_cache: match");
		end else begin
			$display("probe_limited_lru_hash_cache: mismatch");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/pllc_pkg.sv
hw/rtl/pllc_ram.sv
hw/rtl/probe_limited_lru_hash_cache.sv
bench/tb.sv
